>>> hdl/ps2_mouse_host_interface_defines.svh
// assertion macros shared by the ps2 mouse host interface rtl
`ifndef PS2_MOUSE_HOST_INTERFACE_DEFINES_SVH
`define PS2_MOUSE_HOST_INTERFACE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PS2MH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2mh assertion failed");

// next-cycle implication, checked outside reset
`define PS2MH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2mh assertion failed");

`endif

>>> hdl/ps2mh_pkg.sv
// types and constants of the ps2 mouse host interface
`default_nettype none
package ps2mh_pkg;

   // request kinds carried in tuser
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_SEND    = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_STREAM_ENABLE = 2'd0;
   localparam logic [1:0] CSR_INHIBIT_TICKS = 2'd1;
   localparam logic [1:0] CSR_START_TICKS   = 2'd2;
   localparam logic [1:0] CSR_SETTLE_TICKS  = 2'd3;

   // register reset values
   localparam logic [15:0] INHIBIT_TICKS_RST = 16'd300;
   localparam logic [15:0] START_TICKS_RST   = 16'd10;
   localparam logic [15:0] SETTLE_TICKS_RST  = 16'd50;

   // frame and byte geometry
   localparam logic [3:0] FRAME_BITS     = 4'd11;
   localparam logic [3:0] FIRST_DATA_BIT = 4'd1;
   localparam logic [3:0] LAST_DATA_BIT  = 4'd8;
   localparam logic [3:0] SEND_BITS      = 4'd8;

   // packet byte slots
   localparam logic [1:0] SLOT_STATUS = 2'd0;
   localparam logic [1:0] SLOT_DX     = 2'd1;
   localparam logic [1:0] SLOT_DY     = 2'd2;

   // sender phases
   typedef enum logic [11:0] {
      PH_IDLE     = 12'b0000_0000_0001,
      PH_RELEASE  = 12'b0000_0000_0010,
      PH_INHIBIT  = 12'b0000_0000_0100,
      PH_START    = 12'b0000_0000_1000,
      PH_FIRST    = 12'b0000_0001_0000,
      PH_BIT_HIGH = 12'b0000_0010_0000,
      PH_BIT_LOW  = 12'b0000_0100_0000,
      PH_PAR_HIGH = 12'b0000_1000_0000,
      PH_PAR_LOW  = 12'b0001_0000_0000,
      PH_SETTLE   = 12'b0010_0000_0000,
      PH_ACK_LOW  = 12'b0100_0000_0000,
      PH_ACK_HIGH = 12'b1000_0000_0000
   } phase_type;

   // configuration registers
   typedef struct packed {
      logic        stream_enable;
      logic [15:0] inhibit_ticks;
      logic [15:0] start_ticks;
      logic [15:0] settle_ticks;
   } cfg_type;

   // one result word
   typedef struct packed {
      logic       clock_pull_low;
      logic       data_pull_low;
      logic       send_busy;
      logic       send_done;
      logic       packet_ready;
      logic [7:0] packet_status;
      logic [7:0] packet_dx;
      logic [7:0] packet_dy;
   } rsp_type;

endpackage
`default_nettype wire

>>> hdl/ps2mh_core.sv
// line state, receiver and sender of the ps2 mouse host interface
`default_nettype none
`include "ps2_mouse_host_interface_defines.svh"
module ps2mh_core #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [1:0]        req_type,
   input  wire logic [7:0]        tx_byte,
   input  wire logic              clock_level,
   input  wire logic              data_level,
   input  wire ps2mh_pkg::cfg_type cfg,
   output ps2mh_pkg::rsp_type     rsp
);

   localparam logic [31:0] TMAX32 = 32'((64'd1 << TIMER_BITS) - 64'd1);

   // timer load value: zero counts as one, large values saturate
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] ticks);
      logic [31:0] v;
      v = (ticks == 16'd0) ? 32'd1 : {16'd0, ticks};
      if (v > TMAX32) v = TMAX32;
      return TIMER_BITS'(v);
   endfunction

   ps2mh_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]              shift_ff, shift_in;
   logic [3:0]              bit_index_ff, bit_index_in;
   logic                    parity_ff, parity_in;
   logic [TIMER_BITS-1:0]   timer_ff, timer_in;
   logic                    clk_prev_ff, clk_prev_in;
   logic                    held_low_ff, held_low_in;
   logic [3:0]              rcnt_ff, rcnt_in;
   logic [7:0]              rbyte_ff, rbyte_in;
   logic [1:0]              slot_ff, slot_in;
   logic [7:0]              status_ff, status_in;
   logic [7:0]              dx_ff, dx_in;
   logic [7:0]              dy_ff, dy_in;
   logic                    ready_ff, ready_in;

   logic       running;
   logic       run_step;
   logic       rx_edge;
   logic       tmr_end;
   logic       done;
   logic [2:0] rbit_idx;
   logic       cpl;
   logic       dpl;

   assign running  = (phase_ff != ps2mh_pkg::PH_IDLE);
   assign rx_edge  = cfg.stream_enable && !running && clk_prev_ff && !clock_level;
   assign tmr_end  = (timer_ff <= TIMER_BITS'(1));
   assign rbit_idx = 3'(rcnt_ff - 4'd1);

   // next state for one tick
   always_comb begin
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      bit_index_in = bit_index_ff;
      parity_in    = parity_ff;
      timer_in     = timer_ff;
      held_low_in  = held_low_ff;
      rcnt_in      = rcnt_ff;
      rbyte_in     = rbyte_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ready_in     = ready_ff;
      clk_prev_in  = clock_level;
      done         = 1'b0;
      run_step     = running;

      // receiver: one frame bit per falling clock edge
      if (rx_edge) begin
         ready_in = 1'b0;
         if (rcnt_ff >= ps2mh_pkg::FIRST_DATA_BIT && rcnt_ff <= ps2mh_pkg::LAST_DATA_BIT) begin
            rbyte_in[rbit_idx] = rbyte_ff[rbit_idx] | data_level;
         end
         rcnt_in = rcnt_ff + 4'd1;
         if (rcnt_in >= ps2mh_pkg::FRAME_BITS) begin
            case (slot_ff)
               ps2mh_pkg::SLOT_STATUS: begin
                  status_in = rbyte_in;
                  slot_in   = ps2mh_pkg::SLOT_DX;
               end
               ps2mh_pkg::SLOT_DX: begin
                  dx_in   = rbyte_in;
                  slot_in = ps2mh_pkg::SLOT_DY;
               end
               default: begin
                  dy_in    = rbyte_in;
                  slot_in  = ps2mh_pkg::SLOT_STATUS;
                  ready_in = 1'b1;
               end
            endcase
            rcnt_in  = 4'd0;
            rbyte_in = 8'd0;
         end
      end

      // requests
      if (req_type == ps2mh_pkg::REQ_RELEASE) begin
         phase_in    = ps2mh_pkg::PH_IDLE;
         held_low_in = 1'b0;
         run_step    = 1'b0;
      end else if (req_type == ps2mh_pkg::REQ_SEND && !running) begin
         shift_in     = tx_byte;
         bit_index_in = 4'd0;
         parity_in    = 1'b1;
         held_low_in  = 1'b0;
         phase_in     = ps2mh_pkg::PH_RELEASE;
         timer_in     = timer_load(cfg.inhibit_ticks);
      end

      // sender step
      if (run_step) begin
         case (phase_ff)
            ps2mh_pkg::PH_RELEASE: begin
               if (tmr_end) begin
                  phase_in = ps2mh_pkg::PH_INHIBIT;
                  timer_in = timer_load(cfg.inhibit_ticks);
               end else begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end
            end
            ps2mh_pkg::PH_INHIBIT: begin
               if (tmr_end) begin
                  phase_in = ps2mh_pkg::PH_START;
                  timer_in = timer_load(cfg.start_ticks);
               end else begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end
            end
            ps2mh_pkg::PH_START: begin
               if (tmr_end) begin
                  phase_in = ps2mh_pkg::PH_FIRST;
               end else begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end
            end
            ps2mh_pkg::PH_FIRST: begin
               if (!clock_level) phase_in = ps2mh_pkg::PH_BIT_HIGH;
            end
            ps2mh_pkg::PH_BIT_HIGH: begin
               if (clock_level) phase_in = ps2mh_pkg::PH_BIT_LOW;
            end
            ps2mh_pkg::PH_BIT_LOW: begin
               if (!clock_level) begin
                  parity_in    = parity_ff ^ shift_ff[0];
                  shift_in     = shift_ff >> 1;
                  bit_index_in = bit_index_ff + 4'd1;
                  phase_in     = (bit_index_in >= ps2mh_pkg::SEND_BITS) ?
                                 ps2mh_pkg::PH_PAR_HIGH : ps2mh_pkg::PH_BIT_HIGH;
               end
            end
            ps2mh_pkg::PH_PAR_HIGH: begin
               if (clock_level) phase_in = ps2mh_pkg::PH_PAR_LOW;
            end
            ps2mh_pkg::PH_PAR_LOW: begin
               if (!clock_level) begin
                  phase_in = ps2mh_pkg::PH_SETTLE;
                  timer_in = timer_load(cfg.settle_ticks);
               end
            end
            ps2mh_pkg::PH_SETTLE: begin
               if (tmr_end) begin
                  phase_in = ps2mh_pkg::PH_ACK_LOW;
               end else begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end
            end
            ps2mh_pkg::PH_ACK_LOW: begin
               if (!clock_level) phase_in = ps2mh_pkg::PH_ACK_HIGH;
            end
            ps2mh_pkg::PH_ACK_HIGH: begin
               if (clock_level && data_level) begin
                  phase_in    = ps2mh_pkg::PH_IDLE;
                  held_low_in = 1'b1;
                  done        = 1'b1;
               end
            end
            default: begin
               phase_in = ps2mh_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // line drive from the phase the tick ends in
   always_comb begin
      case (phase_in)
         ps2mh_pkg::PH_IDLE: begin
            cpl = held_low_in;
            dpl = 1'b0;
         end
         ps2mh_pkg::PH_INHIBIT: begin
            cpl = 1'b1;
            dpl = 1'b0;
         end
         ps2mh_pkg::PH_START: begin
            cpl = 1'b1;
            dpl = 1'b1;
         end
         ps2mh_pkg::PH_FIRST: begin
            cpl = 1'b0;
            dpl = 1'b1;
         end
         ps2mh_pkg::PH_BIT_HIGH, ps2mh_pkg::PH_BIT_LOW: begin
            cpl = 1'b0;
            dpl = !shift_in[0];
         end
         ps2mh_pkg::PH_PAR_HIGH, ps2mh_pkg::PH_PAR_LOW: begin
            cpl = 1'b0;
            dpl = !parity_in;
         end
         default: begin
            cpl = 1'b0;
            dpl = 1'b0;
         end
      endcase
   end

   // result word for this tick
   always_comb begin
      rsp.clock_pull_low = cpl;
      rsp.data_pull_low  = dpl;
      rsp.send_busy      = (phase_in != ps2mh_pkg::PH_IDLE);
      rsp.send_done      = done;
      rsp.packet_ready   = ready_in;
      rsp.packet_status  = status_in;
      rsp.packet_dx      = dx_in;
      rsp.packet_dy      = dy_in;
   end

   // state update on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ps2mh_pkg::PH_IDLE;
         shift_ff     <= 8'd0;
         bit_index_ff <= 4'd0;
         parity_ff    <= 1'b1;
         timer_ff     <= '0;
         clk_prev_ff  <= 1'b1;
         held_low_ff  <= 1'b0;
         rcnt_ff      <= 4'd0;
         rbyte_ff     <= 8'd0;
         slot_ff      <= ps2mh_pkg::SLOT_STATUS;
         status_ff    <= 8'd0;
         dx_ff        <= 8'd0;
         dy_ff        <= 8'd0;
         ready_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         bit_index_ff <= bit_index_in;
         parity_ff    <= parity_in;
         timer_ff     <= timer_in;
         clk_prev_ff  <= clk_prev_in;
         held_low_ff  <= held_low_in;
         rcnt_ff      <= rcnt_in;
         rbyte_ff     <= rbyte_in;
         slot_ff      <= slot_in;
         status_ff    <= status_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         ready_ff     <= ready_in;
      end
   end

   // a finished send leaves the clock held low and the sender idle
   `PS2MH_ASSERT_NEXT(a_done_holds_clock, clock, reset, accept && done,
      phase_ff == ps2mh_pkg::PH_IDLE && held_low_ff)
   // a release request always ends with both lines free
   `PS2MH_ASSERT_NEXT(a_release_frees, clock, reset,
      accept && req_type == ps2mh_pkg::REQ_RELEASE,
      phase_ff == ps2mh_pkg::PH_IDLE && !held_low_ff)
   // state only moves on an accepted word
   `PS2MH_ASSERT_NEXT(a_hold_when_idle, clock, reset, !accept,
      $stable(phase_ff) && $stable(rcnt_ff) && $stable(timer_ff))
   // receiver never counts while a send runs
   `PS2MH_ASSERT_NOW(a_no_rx_in_send, clock, reset, running, !rx_edge)

endmodule
`default_nettype wire

>>> hdl/ps2_mouse_host_interface.sv
// ps2 mouse host interface: registered single-pass tick processor, 1 word per cycle while req_tready is high
// an accepted tick's result word is registered in the output register, or in the skid stage while that one is full
// throughput: one tick word per clock; a skid stage keeps req_tready high while one
//   result waits, so req_tready drops only when two results are pending
// reset: synchronous, active high; clears sender, receiver, packet bytes and buffers,
//   and loads the registers with 0, 300, 10 and 50
`default_nettype none
module ps2_mouse_host_interface #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tick words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // tx_byte[7:0], clock_level[8], data_level[9]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // clock_pull_low[0], data_pull_low[1],
                                          // send_busy[2], send_done[3], packet_ready[4],
                                          // packet_status[12:5], packet_dx[20:13],
                                          // packet_dy[28:21]
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   ps2mh_pkg::cfg_type cfg_ff;
   ps2mh_pkg::rsp_type rsp_new;
   ps2mh_pkg::rsp_type out_ff;
   ps2mh_pkg::rsp_type skid_ff;
   logic               out_valid_ff;
   logic               skid_valid_ff;
   logic               accept;
   logic               out_fire;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_fire   = out_valid_ff && rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stream_enable <= 1'b0;
         cfg_ff.inhibit_ticks <= ps2mh_pkg::INHIBIT_TICKS_RST;
         cfg_ff.start_ticks   <= ps2mh_pkg::START_TICKS_RST;
         cfg_ff.settle_ticks  <= ps2mh_pkg::SETTLE_TICKS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            ps2mh_pkg::CSR_STREAM_ENABLE: cfg_ff.stream_enable <= csr_wdata[0];
            ps2mh_pkg::CSR_INHIBIT_TICKS: cfg_ff.inhibit_ticks <= csr_wdata;
            ps2mh_pkg::CSR_START_TICKS:   cfg_ff.start_ticks   <= csr_wdata;
            ps2mh_pkg::CSR_SETTLE_TICKS:  cfg_ff.settle_ticks  <= csr_wdata;
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // tick processing
   ps2mh_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_type    (req_tuser),
      .tx_byte     (req_tdata[7:0]),
      .clock_level (req_tdata[8]),
      .data_level  (req_tdata[9]),
      .cfg         (cfg_ff),
      .rsp         (rsp_new)
   );

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_fire) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_ff       <= rsp_new;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= rsp_new;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_ff.packet_dy, out_ff.packet_dx, out_ff.packet_status,
                        out_ff.packet_ready, out_ff.send_done, out_ff.send_busy,
                        out_ff.data_pull_low, out_ff.clock_pull_low};

endmodule
`default_nettype wire
